/* sv/crh_pkg.sv */
// ----------------------------------------------------------------------------
// crh_pkg
// Shared types and constants of the copy ratio histogram engine.
// ----------------------------------------------------------------------------
package crh_pkg;

  localparam int NUM_BINS   = 1024;
  localparam int COUNT_BITS = 24;
  localparam int WGT_W      = 17;
  localparam int QBIN_W     = 10;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int VAL_W      = 32;
  localparam int TOT_W      = 48;
  localparam int DIV_W      = COUNT_BITS + WGT_W;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic SIDE_ASM  = 1'b0;
  localparam logic SIDE_READ = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic              kmer_valid;
    logic [23:0]       read_count;
    logic [23:0]       asm_count;
    logic [WGT_W-1:0]  weight;
    logic              query_side;
    logic [QBIN_W-1:0] query_bin;
  } crh_in_t;

  typedef struct packed {
    logic              result_kind;
    logic              missing_flag;
    logic              bin_side;
    logic [QBIN_W-1:0] bin_number;
    logic [VAL_W-1:0]  bin_value;
    logic [TOT_W-1:0]  missing_total;
    logic [TOT_W-1:0]  kmer_total;
    logic [TOT_W-1:0]  overcopy_total;
  } crh_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_DIV_R, ST_DIV_O, ST_MRD, ST_MUPD, ST_FIN
  } crh_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic cnt_kmer;
    logic cnt_miss;
    logic top_bin;
    logic div_start;
    logic div_sel_over;
    logic take_ratio;
    logic take_over;
    logic mem_upd;
    logic out_load;
  } crh_cmd_t;

  typedef struct packed {
    logic op_query;
    logic kvalid;
    logic rd_zero;
    logic as_zero;
    logic as_gt;
    logic div_done;
    logic clr_last;
    logic out_free;
  } crh_stat_t;

endpackage

/* sv/crh_ram.sv */
// ----------------------------------------------------------------------------
// crh_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module crh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/crh_div.sv */
// ----------------------------------------------------------------------------
// crh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crh_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [crh_pkg::DIV_W-1:0] num,
  input  logic [crh_pkg::DIV_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [crh_pkg::DIV_W-1:0] quo
);
  import crh_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r;
  logic [DIV_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIV_W'(trial - {1'b0, den_r}) : DIV_W'(trial);
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* sv/crh_ctrl.sv */
// ----------------------------------------------------------------------------
// crh_ctrl
// Sequencer: clearing pass, decode, divisions, bin update, result hand-off.
// ----------------------------------------------------------------------------
module crh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crh_pkg::crh_stat_t stat,
  output crh_pkg::crh_cmd_t  cmd
);
  import crh_pkg::*;

  crh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (stat.op_query) begin
          state_nxt = ST_MRD;
        end else if (!stat.kvalid) begin
          state_nxt = ST_FIN;
        end else if (stat.rd_zero) begin
          cmd.cnt_kmer = 1'b1;
          cmd.cnt_miss = 1'b1;
          state_nxt    = ST_FIN;
        end else if (stat.as_zero) begin
          cmd.cnt_kmer = 1'b1;
          cmd.top_bin  = 1'b1;
          state_nxt    = ST_MRD;
        end else begin
          cmd.cnt_kmer  = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (stat.div_done) begin
          cmd.take_ratio = 1'b1;
          if (stat.as_gt) begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_over = 1'b1;
            state_nxt        = ST_DIV_O;
          end else begin
            state_nxt = ST_MRD;
          end
        end
      end
      ST_DIV_O: begin
        if (stat.div_done) begin
          cmd.take_over = 1'b1;
          state_nxt     = ST_MRD;
        end
      end
      ST_MRD: begin
        state_nxt = ST_MUPD;
      end
      ST_MUPD: begin
        cmd.mem_upd = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/crh_datapath.sv */
// ----------------------------------------------------------------------------
// crh_datapath
// Item registers, ratio and over-copy arithmetic, bin memories, totals and
// the output register.
// ----------------------------------------------------------------------------
module crh_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  crh_pkg::crh_in_t   in_data,
  input  crh_pkg::crh_cmd_t  cmd,
  output crh_pkg::crh_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output crh_pkg::crh_out_t  out_data
);
  import crh_pkg::*;

  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  logic                  op_r, kv_r, qrange_r;
  logic [COUNT_BITS-1:0] rd_r, as_r, big, lesser;
  logic [WGT_W-1:0]      w_r;
  logic [DIV_W-1:0]      prod_r, ratio_num, ratio_den, div_num, div_den, div_quo;
  logic                  div_busy, div_done;
  logic [BIN_W-1:0]      idx_r, clr_cnt_r, mem_addr;
  logic                  res_kind_r, res_miss_r, res_side_r;
  logic [QBIN_W-1:0]     res_bin_r;
  logic [VAL_W-1:0]      res_val_r, asm_rdata, rd_rdata, cur_val, bumped;
  logic [TOT_W-1:0]      miss_r, kmer_r, ovc_r;
  logic [TOT_W:0]        ovc_sum;
  logic                  as_gt, we_asm, we_read;
  logic                  out_valid_r;
  crh_out_t              out_r;

  assign as_gt  = as_r > rd_r;
  assign big    = as_gt ? as_r : rd_r;
  assign lesser = as_gt ? rd_r : as_r;

  assign ratio_num = (DIV_W'(big) << 3) + (DIV_W'(big) << 1)
                   - (DIV_W'(lesser) << 3) - DIV_W'(lesser);
  assign ratio_den = DIV_W'(lesser) << 1;
  assign div_num   = cmd.div_sel_over ? prod_r : ratio_num;
  assign div_den   = cmd.div_sel_over ? DIV_W'(as_r) : ratio_den;

  crh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign mem_addr = cmd.clear ? clr_cnt_r : idx_r;
  assign we_asm   = cmd.clear || (cmd.mem_upd && !op_r && res_side_r == SIDE_ASM);
  assign we_read  = cmd.clear || (cmd.mem_upd && !op_r && res_side_r == SIDE_READ);
  assign cur_val  = (res_side_r == SIDE_READ) ? rd_rdata : asm_rdata;
  assign bumped   = (cur_val == VAL_MAX) ? VAL_MAX : cur_val + 1'b1;

  crh_ram #(.WIDTH(VAL_W), .DEPTH(NUM_BINS)) u_asm_bins (
    .clk   (clk),
    .we    (we_asm),
    .addr  (mem_addr),
    .wdata (cmd.clear ? '0 : bumped),
    .rdata (asm_rdata)
  );

  crh_ram #(.WIDTH(VAL_W), .DEPTH(NUM_BINS)) u_read_bins (
    .clk   (clk),
    .we    (we_read),
    .addr  (mem_addr),
    .wdata (cmd.clear ? '0 : bumped),
    .rdata (rd_rdata)
  );

  assign ovc_sum = {1'b0, ovc_r} + (TOT_W + 1)'(div_quo);

  always_ff @(posedge clk) begin
    prod_r <= DIV_W'(as_r - rd_r) * DIV_W'(w_r);
    if (cmd.load) begin
      op_r       <= in_data.opcode;
      kv_r       <= in_data.kmer_valid;
      rd_r       <= COUNT_BITS'(in_data.read_count);
      as_r       <= COUNT_BITS'(in_data.asm_count);
      w_r        <= in_data.weight;
      qrange_r   <= 32'(in_data.query_bin) < NUM_BINS;
      idx_r      <= BIN_W'(in_data.query_bin);
      res_kind_r <= in_data.opcode;
      res_miss_r <= 1'b0;
      res_side_r <= (in_data.opcode == OP_QUERY) ? in_data.query_side : SIDE_ASM;
      res_bin_r  <= (in_data.opcode == OP_QUERY) ? in_data.query_bin : '0;
      res_val_r  <= '0;
    end
    if (cmd.cnt_miss) res_miss_r <= 1'b1;
    if (cmd.top_bin) begin
      idx_r      <= BIN_W'(NUM_BINS - 1);
      res_side_r <= SIDE_READ;
    end
    if (cmd.take_ratio) begin
      idx_r      <= (div_quo >= DIV_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                      : BIN_W'(div_quo);
      res_side_r <= as_gt ? SIDE_ASM : SIDE_READ;
    end
    if (cmd.mem_upd) begin
      res_bin_r <= op_r ? res_bin_r : QBIN_W'(idx_r);
      res_val_r <= op_r ? (qrange_r ? cur_val : '0) : bumped;
    end
    if (cmd.out_load) begin
      out_r.result_kind    <= res_kind_r;
      out_r.missing_flag   <= res_miss_r;
      out_r.bin_side       <= res_side_r;
      out_r.bin_number     <= res_bin_r;
      out_r.bin_value      <= res_val_r;
      out_r.missing_total  <= miss_r;
      out_r.kmer_total     <= kmer_r;
      out_r.overcopy_total <= ovc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r      <= '0;
      kmer_r      <= '0;
      ovc_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.cnt_kmer && kmer_r != TOT_MAX) kmer_r <= kmer_r + 1'b1;
      if (cmd.cnt_miss && miss_r != TOT_MAX) miss_r <= miss_r + 1'b1;
      if (cmd.take_over) ovc_r <= ovc_sum[TOT_W] ? TOT_MAX : ovc_sum[TOT_W-1:0];
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat          = '0;
    stat.op_query = op_r;
    stat.kvalid   = kv_r;
    stat.rd_zero  = rd_r == '0;
    stat.as_zero  = as_r == '0;
    stat.as_gt    = as_gt;
    stat.div_done = div_done;
    stat.clr_last = clr_cnt_r == BIN_W'(NUM_BINS - 1);
    stat.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_kmer_ge_miss: assert property (@(posedge clk) disable iff (!rst_n)
    kmer_r >= miss_r) else $error("missing total above k-mer total");

  a_ovc_mono: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_over |=> ovc_r >= $past(ovc_r)) else $error("over-copy sum went down");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r) else $error("loaded word not presented");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !div_busy && $past(div_busy)) else $error("divider done without run");

endmodule

/* sv/copy_ratio_histogram_top.sv */
// ----------------------------------------------------------------------------
// copy_ratio_histogram_top
// K-mer copy ratio histogram engine with bin read-back.
// ----------------------------------------------------------------------------
// After reset both 1024-bin histograms are cleared while the input is
// stalled. Items are then taken one at a time. A count word that needs a ratio
// goes through the shared restoring divider, which yields one quotient bit per
// cycle, once for the read-excess side and twice for the assembly-excess side;
// invalid, missing and zero-assembly words skip it. The next word is accepted
// while a result waits.
// ----------------------------------------------------------------------------
module copy_ratio_histogram_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  crh_pkg::crh_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output crh_pkg::crh_out_t out_data
);
  import crh_pkg::*;

  crh_cmd_t  cmd;
  crh_stat_t stat;

  crh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  crh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the copy ratio histogram engine.
// ----------------------------------------------------------------------------
// A directed table covers reset contents, skipped and missing k-mers, equal
// counts, zero assembly counts, count extremes and read-back of the edge bins.
// About a thousand random count and read-back words follow. Both sides idle at
// random, and the receiver holds off for one long stretch. Every result is
// checked in order against a table entry or a local model of bins and totals.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import crh_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  crh_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  crh_out_t out_data;

  copy_ratio_histogram_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [VAL_W-1:0] asm_hist [NUM_BINS];
  logic [VAL_W-1:0] read_hist [NUM_BINS];
  logic [TOT_W-1:0] missing_sum, kmer_sum, overcopy_sum;
  crh_out_t         pending_results[$];
  int               mismatches = 0;
  int               results_seen = 0;
  int               count_words = 0, query_words = 0;
  bit               quiet = 1'b0;
  bit               hold_req = 1'b0;

  crh_in_t  dir_word[$];
  crh_out_t dir_exp[$];
  bit       dir_known[$];

  function automatic logic [TOT_W-1:0] add_sat48(logic [TOT_W-1:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {16'd0, a} + b;
    return (s > 64'hFFFF_FFFF_FFFF) ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

  function automatic logic [9:0] copy_ratio_bin(logic [63:0] big, logic [63:0] lit);
    logic [63:0] q;
    q = (64'd10 * big - 64'd9 * lit) / (64'd2 * lit);
    return (q >= NUM_BINS - 1) ? 10'(NUM_BINS - 1) : q[9:0];
  endfunction

  function automatic crh_out_t predict_histogram(crh_in_t w);
    crh_out_t    r;
    logic [63:0] rd, as, wt;
    r = '0;
    rd = {40'd0, w.read_count};
    as = {40'd0, w.asm_count};
    wt = {47'd0, w.weight};
    if (w.opcode == OP_QUERY) begin
      r.result_kind = 1'b1;
      r.bin_side = w.query_side;
      r.bin_number = w.query_bin;
      r.bin_value = (w.query_side == SIDE_READ) ? read_hist[w.query_bin]
                                                : asm_hist[w.query_bin];
    end else if (w.kmer_valid) begin
      kmer_sum = add_sat48(kmer_sum, 64'd1);
      if (rd == 0) begin
        missing_sum = add_sat48(missing_sum, 64'd1);
        r.missing_flag = 1'b1;
      end else if (as > rd) begin
        r.bin_side = SIDE_ASM;
        r.bin_number = copy_ratio_bin(as, rd);
        if (asm_hist[r.bin_number] != '1) asm_hist[r.bin_number]++;
        r.bin_value = asm_hist[r.bin_number];
        overcopy_sum = add_sat48(overcopy_sum, ((as - rd) * wt) / as);
      end else begin
        r.bin_side = SIDE_READ;
        r.bin_number = (as == 0) ? 10'(NUM_BINS - 1) : copy_ratio_bin(rd, as);
        if (read_hist[r.bin_number] != '1) read_hist[r.bin_number]++;
        r.bin_value = read_hist[r.bin_number];
      end
    end
    r.missing_total = missing_sum;
    r.kmer_total = kmer_sum;
    r.overcopy_total = overcopy_sum;
    return r;
  endfunction

  function automatic crh_in_t count_word(bit v, int rd, int as, int wt);
    crh_in_t w;
    w = '0;
    w.opcode = OP_COUNT;
    w.kmer_valid = v;
    w.read_count = 24'(rd);
    w.asm_count = 24'(as);
    w.weight = WGT_W'(wt);
    return w;
  endfunction

  function automatic crh_in_t query_word(logic side, int b);
    crh_in_t w;
    w = '0;
    w.opcode = OP_QUERY;
    w.query_side = side;
    w.query_bin = QBIN_W'(b);
    return w;
  endfunction

  task automatic add_row(crh_in_t w, bit known, crh_out_t e);
    dir_word.push_back(w);
    dir_known.push_back(known);
    dir_exp.push_back(e);
  endtask

  task automatic send_word(crh_in_t w, bit known, crh_out_t e);
    int          gap;
    crh_out_t    p;
    logic [95:0] junk;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      junk = {$urandom, $urandom, $urandom};
      in_valid <= 1'b0;
      in_data <= junk[$bits(crh_in_t)-1:0];
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    p = predict_histogram(w);
    pending_results.push_back(known ? e : p);
    if (w.opcode == OP_QUERY) query_words++;
    else count_words++;
    @(negedge clk);
  endtask

  function automatic int rand_count();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(24'hFFFFFF);
      2: return $urandom_range(24'hFFFFFF, 24'hF00000);
      3, 4: return $urandom_range(1000, 1);
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  function automatic crh_in_t rand_word();
    int rd, as;
    if ($urandom_range(99) < 20)
      return query_word($urandom_range(1),
                        ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(120));
    rd = rand_count();
    as = ($urandom_range(9) == 0) ? rd : rand_count();
    return count_word($urandom_range(99) >= 8, rd, as,
                      ($urandom_range(3) == 0) ? 65536 : $urandom_range(17'h1FFFF));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        crh_out_t e;
        e = pending_results.pop_front();
        if (out_data.result_kind !== e.result_kind || out_data.missing_flag !== e.missing_flag
            || out_data.bin_side !== e.bin_side || out_data.bin_number !== e.bin_number
            || out_data.bin_value !== e.bin_value || out_data.missing_total !== e.missing_total
            || out_data.kmer_total !== e.kmer_total
            || out_data.overcopy_total !== e.overcopy_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t\n  exp %p\n  got %p", $realtime, e, out_data);
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= (!quiet && $urandom_range(99) < 21);
      end
    end
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[copy_ratio_histogram_top] ERROR");
    $finish;
  end

  initial begin
    crh_out_t e;
    int       wait_cycles;
    foreach (asm_hist[i]) begin
      asm_hist[i] = '0;
      read_hist[i] = '0;
    end
    missing_sum = '0;
    kmer_sum = '0;
    overcopy_sum = '0;

    // after reset
    e = '0; e.result_kind = 1'b1;
    add_row(query_word(SIDE_ASM, 0), 1'b1, e);
    e = '0;
    add_row(count_word(1'b0, 24'hFFFFFF, 7, 65536), 1'b1, e);
    e = '0; e.missing_flag = 1'b1; e.missing_total = 1; e.kmer_total = 1;
    add_row(count_word(1'b1, 0, 24'hFFFFFF, 17'h1FFFF), 1'b1, e);
    e = '0; e.bin_side = SIDE_READ; e.bin_value = 1; e.missing_total = 1; e.kmer_total = 2;
    add_row(count_word(1'b1, 5, 5, 65536), 1'b1, e);
    e = '0;
    add_row(count_word(1'b1, 7, 0, 100), 1'b0, e);
    add_row(count_word(1'b1, 1, 24'hFFFFFF, 17'h1FFFF), 1'b0, e);
    add_row(count_word(1'b1, 24'hFFFFFF, 1, 0), 1'b0, e);
    add_row(count_word(1'b1, 24'hFFFFFF, 24'hFFFFFF, 17'h1FFFF), 1'b0, e);
    add_row(count_word(1'b1, 10, 13, 65536), 1'b0, e);
    add_row(count_word(1'b1, 10, 13, 0), 1'b0, e);
    add_row(count_word(1'b1, 24'hFFFFFE, 24'hFFFFFF, 17'h10001), 1'b0, e);
    add_row(count_word(1'b1, 3, 2, 1), 1'b0, e);
    add_row(count_word(1'b1, 24'h800000, 24'h7FFFFF, 65536), 1'b0, e);
    add_row(count_word(1'b1, 0, 0, 0), 1'b0, e);
    add_row(query_word(SIDE_READ, 1023), 1'b0, e);
    add_row(query_word(SIDE_ASM, 1023), 1'b0, e);
    add_row(query_word(SIDE_READ, 0), 1'b0, e);
    add_row(query_word(SIDE_ASM, 2), 1'b0, e);
    add_row(query_word(SIDE_READ, 10'h2AA), 1'b0, e);
    add_row(query_word(SIDE_ASM, 10'h155), 1'b0, e);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_word[i]) send_word(dir_word[i], dir_known[i], dir_exp[i]);

    for (int n = 0; n < 1030; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 500) quiet = 1'b1;
      if (n == 700) quiet = 1'b0;
      if (n == 800) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      send_word(rand_word(), 1'b0, e);
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);

    $display("covered %0d count words and %0d read-back words, %0d results checked",
             count_words, query_words, results_seen);
    $display("final totals: kmers %0d, missing %0d, over-copy %0d (Q16), mismatches %0d",
             kmer_sum, missing_sum, overcopy_sum, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[copy_ratio_histogram_top] OK");
    end else begin
      $display("%0d results never arrived", pending_results.size());
      $display("[copy_ratio_histogram_top] ERROR");
    end
    $finish;
  end

endmodule
